// ----- hw/rtl/emt_pkg.sv -----
package emt_pkg;

	// Table geometry
	localparam int MARK_ENTRIES = 16;
	localparam int PAGE_SHIFT   = 12;
	localparam int THREAD_BITS  = 16;

	// Field widths on the stream ports
	localparam int ADDR_W  = 32;
	localparam int TID_W   = 16;
	localparam int REQ_W   = 2;
	localparam int COUNT_W = 5;

	// Derived widths
	localparam int IDX_W    = $clog2(MARK_ENTRIES);
	localparam int THREAD_W = (THREAD_BITS < TID_W) ? THREAD_BITS : TID_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD         = 2'd0,
		REQ_CLEAN       = 2'd1,
		REQ_REMOVE_SELF = 2'd2
	} req_t;

	// One stored mark
	typedef struct packed {
		logic [ADDR_W-1:0]   address;
		logic [THREAD_W-1:0] thread;
	} entry_t;

	// Compare results for one entry against the request
	typedef struct packed {
		logic hit_other;
		logic hit_self;
		logic page_hit;
	} match_t;

endpackage

// ----- hw/rtl/emt_mark_ram.sv -----
module emt_mark_ram
	import emt_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data
);

	entry_t mem_q [MARK_ENTRIES];

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_idx];
		end
	end

endmodule

// ----- hw/rtl/emt_match_unit.sv -----
module emt_match_unit
	import emt_pkg::*;
(
	input  logic                entry_valid,
	input  entry_t              entry,
	input  logic [ADDR_W-1:0]   req_address,
	input  logic [THREAD_W-1:0] req_thread,
	output match_t              result
);

	logic addr_eq;
	logic thr_eq;
	logic page_eq;

	// One address, thread and page compare, reused for every entry in turn
	assign addr_eq = (entry.address == req_address);
	assign thr_eq  = (entry.thread == req_thread);
	assign page_eq = (entry.address[ADDR_W-1:PAGE_SHIFT] == req_address[ADDR_W-1:PAGE_SHIFT]);

	assign result.hit_other = entry_valid & addr_eq & ~thr_eq;
	assign result.hit_self  = entry_valid & addr_eq & thr_eq;
	assign result.page_hit  = entry_valid & page_eq;

endmodule

// ----- hw/rtl/exclusive_monitor_table_top.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: address, thread_id; tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: removed_count, page_empty, table_full
//
// Each request is accepted, then every entry is read in turn through the shared compare unit
// behind the mark RAM read port; a drain step lets the last read land, and a finish step
// reports the result.
// Reset clears every valid bit at once; the mark RAM needs no clearing pass.
// The result sits in an output register, so a new request is taken while it waits;
// the report step holds until that register is free.
module exclusive_monitor_table_top
	import emt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [31:0] address, [47:32] thread_id
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [4:0] removed_count, [5] page_empty,
	                                    // [6] table_full, [7] zero
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MARK_ENTRIES - 1);

	state_t              state_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_s1;
	logic                vld_s1;
	logic [MARK_ENTRIES-1:0] valid_q;
	req_t                req_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [THREAD_W-1:0] thread_q;
	logic [COUNT_W-1:0]  removed_q;
	logic                left_q;
	logic                placed_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_empty_q;
	logic                out_full_q;

	logic   in_fire;
	logic   issue;
	logic   set_en;
	logic   clr_en;
	logic   out_load;
	entry_t wr_data;
	entry_t rd_data;
	match_t hit;
	logic   res_empty;
	logic   res_full;
	logic [COUNT_W-1:0] res_count;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign issue         = (state_q == ST_SCAN);

	// Mark storage
	assign wr_data.address = addr_q;
	assign wr_data.thread  = thread_q;

	emt_mark_ram u_ram (
		.clk     (clk),
		.wr_en   (set_en),
		.wr_idx  (cnt_q),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_idx  (cnt_q),
		.rd_data (rd_data)
	);

	emt_match_unit u_match (
		.entry_valid (vld_s1 & valid_q[idx_s1]),
		.entry       (rd_data),
		.req_address (addr_q),
		.req_thread  (thread_q),
		.result      (hit)
	);

	// Per-entry actions
	assign set_en = issue & (req_q == REQ_ADD) & ~placed_q & ~valid_q[cnt_q];
	assign clr_en = ((req_q == REQ_CLEAN) & hit.hit_other) |
	                ((req_q == REQ_REMOVE_SELF) & hit.hit_self & (removed_q == '0));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= cnt_q;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (set_en) begin
				valid_q[cnt_q] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	// Request capture and running results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q <= '0;
			left_q    <= 1'b0;
			placed_q  <= 1'b0;
		end else if (in_fire) begin
			removed_q <= '0;
			left_q    <= 1'b0;
			placed_q  <= 1'b0;
		end else begin
			if (set_en) begin
				placed_q <= 1'b1;
			end
			if (clr_en && (removed_q != COUNT_MAX)) begin
				removed_q <= removed_q + 1'b1;
			end
			if ((req_q == REQ_CLEAN) && hit.page_hit && !hit.hit_other) begin
				left_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q    <= req_t'(s_axis_tuser);
			addr_q   <= s_axis_tdata[ADDR_W-1:0];
			thread_q <= s_axis_tdata[ADDR_W +: THREAD_W];
		end
	end

	// Result selection by request type
	always_comb begin
		res_count = '0;
		res_empty = 1'b0;
		res_full  = 1'b0;
		case (req_q)
			REQ_ADD: begin
				res_full = ~placed_q;
			end
			REQ_CLEAN: begin
				res_count = removed_q;
				res_empty = ~left_q;
			end
			REQ_REMOVE_SELF: begin
				res_count = removed_q;
			end
			default: begin
				res_count = '0;
			end
		endcase
	end

	// Output register
	assign out_load = (state_q == ST_FINISH) & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= res_count;
			out_empty_q <= res_empty;
			out_full_q  <= res_full;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_full_q, out_empty_q, out_count_q};

	// Checks
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SCAN) && (cnt_q == '0))
		else $error("accepted request did not start a scan at entry zero");

	a_remove_self_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && (req_q == REQ_REMOVE_SELF) |-> (removed_q <= 1))
		else $error("remove-self removed more than one mark");

	a_full_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_full |-> (req_q == REQ_ADD))
		else $error("table full reported for a request other than add");

	a_one_set_per_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= $countones($past(valid_q)) + 1)
		else $error("more than one mark placed in a cycle");

	a_add_places_once: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |=> placed_q)
		else $error("placement not recorded after an add");

endmodule

// ----- tb/tb_exclusive_monitor_table_top.sv -----
module tb_exclusive_monitor_table_top;
	import emt_pkg::*;

	// Request code with no meaning to the block: ignored, all-zero result
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int RANDOM_PER_PHASE = 434;
	localparam int HOLD_AFTER       = 1000;
	localparam int HOLD_CYCLES      = 400;
	localparam int DRAIN_CYCLES     = 3 * MARK_ENTRIES;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               empty;
		logic               full;
	} outcome_t;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
		logic [TID_W-1:0]  tid;
		bit                typed;
		outcome_t          res;
	} dir_row_t;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata  = '0;  // [31:0] address, [47:32] thread_id
	logic [1:0]        s_axis_tuser  = '0;  // [1:0] req_type
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [4:0] removed_count, [5] page_empty,
	                                        // [6] table_full, [7] zero

	// Shadow copy of the mark table
	bit                  shadow_valid [MARK_ENTRIES];
	logic [ADDR_W-1:0]   shadow_addr  [MARK_ENTRIES];
	logic [THREAD_W-1:0] shadow_thread[MARK_ENTRIES];

	outcome_t pending_outcomes[$];
	dir_row_t directed_rows[$];
	int       mismatches   = 0;
	int       tx_idle_pct  = 10;
	int       rx_idle_pct  = 84;

	logic [ADDR_W-1:0] addr_pool[8];
	logic [TID_W-1:0]  thread_pool[4];

	exclusive_monitor_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#1600000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Apply one request to the shadow table and return what the block should report
	function automatic outcome_t apply_request(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
			logic [TID_W-1:0] tid_in);
		outcome_t            r;
		logic [THREAD_W-1:0] tid;
		bit                  done;
		bit                  left;
		r    = '0;
		tid  = tid_in[THREAD_W-1:0];
		done = 0;
		left = 0;
		case (req)
			REQ_ADD: begin
				for (int i = 0; i < MARK_ENTRIES; i++) begin
					if (!done && !shadow_valid[i]) begin
						shadow_valid[i]  = 1;
						shadow_addr[i]   = addr;
						shadow_thread[i] = tid;
						done = 1;
					end
				end
				r.full = !done;
			end
			REQ_CLEAN: begin
				for (int i = 0; i < MARK_ENTRIES; i++) begin
					if (shadow_valid[i] && shadow_addr[i] == addr && shadow_thread[i] != tid) begin
						shadow_valid[i] = 0;
						if (r.count < COUNT_MAX)
							r.count = r.count + 1'b1;
					end
				end
				for (int i = 0; i < MARK_ENTRIES; i++)
					if (shadow_valid[i] && (shadow_addr[i] >> PAGE_SHIFT) == (addr >> PAGE_SHIFT))
						left = 1;
				r.empty = !left;
			end
			REQ_REMOVE_SELF: begin
				for (int i = 0; i < MARK_ENTRIES; i++) begin
					if (!done && shadow_valid[i] && shadow_addr[i] == addr
							&& shadow_thread[i] == tid) begin
						shadow_valid[i] = 0;
						r.count = 1;
						done = 1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random live entry, or -1 when the table is empty
	function automatic int pick_live_mark();
		int idx[$];
		for (int i = 0; i < MARK_ENTRIES; i++)
			if (shadow_valid[i])
				idx.push_back(i);
		if (idx.size() == 0)
			return -1;
		return idx[$urandom_range(idx.size() - 1)];
	endfunction

	// Offer one transaction; on acceptance record its expected outcome
	task automatic offer_request(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
			logic [TID_W-1:0] tid, bit typed, outcome_t typed_res);
		outcome_t pred;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tid, addr};
		s_axis_tuser  <= req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pred = apply_request(req, addr, tid);
		pending_outcomes.push_back(typed ? typed_res : pred);
	endtask

	task automatic add_row(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
			logic [TID_W-1:0] tid, bit typed = 0, outcome_t res = '0);
		dir_row_t row;
		row.req   = req;
		row.addr  = addr;
		row.tid   = tid;
		row.typed = typed;
		row.res   = res;
		directed_rows.push_back(row);
	endtask

	// Random request: mostly built around live marks and a small pool of addresses
	task automatic random_request();
		logic [REQ_W-1:0]  req;
		logic [ADDR_W-1:0] addr;
		logic [TID_W-1:0]  tid;
		int                sel;
		int                live;
		sel  = $urandom_range(99);
		req  = (sel < 40) ? REQ_ADD : (sel < 65) ? REQ_CLEAN :
			(sel < 95) ? REQ_REMOVE_SELF : REQ_UNKNOWN;
		addr = addr_pool[$urandom_range(7)];
		tid  = thread_pool[$urandom_range(3)];
		live = pick_live_mark();
		if (req != REQ_ADD && live >= 0 && $urandom_range(99) < 70) begin
			addr = shadow_addr[live];
			if (req == REQ_REMOVE_SELF)
				tid = shadow_thread[live];
		end
		// Noise: anything at all
		if ($urandom_range(99) < 15) begin
			addr = $urandom;
			tid  = TID_W'($urandom);
		end
		offer_request(req, addr, tid, 0, '0);
	endtask

	// Receiver: random back-pressure plus one long hold so the block fills up
	initial begin
		int  taken;
		bit  held;
		taken = 0;
		held  = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				taken++;
			if (!held && taken >= HOLD_AFTER) begin
				held = 1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.count = m_axis_tdata[4:0];
			got.empty = m_axis_tdata[5];
			got.full  = m_axis_tdata[6];
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result count=%0d empty=%0b full=%0b",
					$time, got.count, got.empty, got.full);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (got.count !== want.count) begin
					$display("%0t: removed_count expected %0d actual %0d",
						$time, want.count, got.count);
					mismatches++;
				end
				if (got.empty !== want.empty) begin
					$display("%0t: page_empty expected %0b actual %0b",
						$time, want.empty, got.empty);
					mismatches++;
				end
				if (got.full !== want.full) begin
					$display("%0t: table_full expected %0b actual %0b",
						$time, want.full, got.full);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		logic [19:0] pages[3];
		outcome_t    z;
		z = '0;
		for (int i = 0; i < MARK_ENTRIES; i++)
			shadow_valid[i] = 0;
		for (int i = 0; i < 3; i++)
			pages[i] = 20'($urandom);
		for (int i = 0; i < 8; i++)
			addr_pool[i] = {pages[$urandom_range(2)], 12'($urandom_range(4095))};
		for (int i = 0; i < 4; i++)
			thread_pool[i] = TID_W'($urandom);

		// Empty table: nothing to remove, page reported empty, unknown type ignored
		add_row(REQ_REMOVE_SELF, 32'h0000_0000, 16'h0000, 1, z);
		add_row(REQ_CLEAN,       32'hFFFF_FFFF, 16'hFFFF, 1, '{count: 0, empty: 1, full: 0});
		add_row(REQ_UNKNOWN,     32'hFFFF_FFFF, 16'hFFFF, 1, z);
		// Fill the table, with a duplicate mark and extreme fields
		add_row(REQ_ADD, 32'h0000_1000, 16'h0001);
		add_row(REQ_ADD, 32'h0000_1000, 16'h0002);
		add_row(REQ_ADD, 32'h0000_1000, 16'h0003);
		add_row(REQ_ADD, 32'h0000_1000, 16'h0001);
		add_row(REQ_ADD, 32'h0000_1004, 16'h0005);
		add_row(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF);
		add_row(REQ_ADD, 32'h0000_0000, 16'h0000);
		add_row(REQ_ADD, 32'h0000_1000, 16'h8000);
		add_row(REQ_ADD, 32'h8000_0000, 16'h7FFF);
		add_row(REQ_ADD, 32'h5555_5555, 16'hAAAA);
		add_row(REQ_ADD, 32'hAAAA_AAAA, 16'h5555);
		add_row(REQ_ADD, 32'h0000_2000, 16'h0001);
		add_row(REQ_ADD, 32'h0000_0FFF, 16'h0002);
		add_row(REQ_ADD, 32'h1234_5678, 16'h0009);
		add_row(REQ_ADD, 32'hDEAD_BEEF, 16'h0003);
		add_row(REQ_ADD, 32'h0000_3000, 16'h0004);
		// No free entry left
		add_row(REQ_ADD, 32'h0000_4000, 16'h0007, 1, '{count: 0, empty: 0, full: 1});
		// Clean leaves own marks and the neighbour in the page
		add_row(REQ_CLEAN, 32'h0000_1000, 16'h0001);
		// Both copies of the duplicate go, then nothing left to remove
		add_row(REQ_REMOVE_SELF, 32'h0000_1000, 16'h0001);
		add_row(REQ_REMOVE_SELF, 32'h0000_1000, 16'h0001);
		add_row(REQ_REMOVE_SELF, 32'h0000_1000, 16'h0001);
		// Last mark in the page: count reported together with page empty
		add_row(REQ_CLEAN, 32'h0000_1004, 16'h0009);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_request(directed_rows[i].req, directed_rows[i].addr, directed_rows[i].tid,
				directed_rows[i].typed, directed_rows[i].res);

		// Sender light, receiver heavy; then swapped; then both flat out
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 84 : 0;
			rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 10 : 0;
			repeat (RANDOM_PER_PHASE)
				random_request();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- exclusive_monitor_table_top.f -----
hw/rtl/emt_pkg.sv
hw/rtl/emt_mark_ram.sv
hw/rtl/emt_match_unit.sv
hw/rtl/exclusive_monitor_table_top.sv
tb/tb_exclusive_monitor_table_top.sv
